// ----- hdl/qspi_fifo_controller_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the quad-SPI queue controller
// Shared wrappers for concurrent checks.
// ---------------------------------------------------------------------------
`ifndef QSPI_FIFO_CONTROLLER_MACROS_SVH
`define QSPI_FIFO_CONTROLLER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define QSPI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define QSPI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/qspi_pkg.sv -----
// ---------------------------------------------------------------------------
// Quad-SPI queue controller package
// Register offsets, operation codes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none
package qspi_pkg;
  localparam int FifoDepthDefault = 64;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [5:0] OFF_CTRL   = 6'd0;
  localparam logic [5:0] OFF_STATUS = 6'd1;
  localparam logic [5:0] OFF_IRQ_EN = 6'd2;
  localparam logic [5:0] OFF_IRQ_DIS = 6'd3;
  localparam logic [5:0] OFF_IRQ_MASK = 6'd4;
  localparam logic [5:0] OFF_ENABLE = 6'd5;
  localparam logic [5:0] OFF_TXD4   = 6'd7;
  localparam logic [5:0] OFF_RXD    = 6'd8;
  localparam logic [5:0] OFF_TX_THR = 6'd10;
  localparam logic [5:0] OFF_RX_THR = 6'd11;
  localparam logic [5:0] OFF_TXD1   = 6'h20;
  localparam logic [5:0] OFF_TXD2   = 6'h21;
  localparam logic [5:0] OFF_TXD3   = 6'h22;

  localparam logic [6:0] IRQ_BITS = 7'h7d;
  localparam int CR_START_BIT = 16;
  localparam int CR_CS_OFF_BIT = 10;

  localparam logic [0:0] CFG_TX_THR = 1'b0;
  localparam logic [0:0] CFG_RX_THR = 1'b1;

  // Result of one request, handed from the datapath to the output register.
  typedef struct packed {
    logic [31:0] read_data;
    logic        serial_out_valid;
    logic [7:0]  serial_out_byte;
  } result_t;
endpackage
`default_nettype wire

// ----- hdl/qspi_fifo_mem.sv -----
// ---------------------------------------------------------------------------
// Queue storage
// Synchronous single-port-write, single-port-read memory with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module qspi_fifo_mem #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]              rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hdl/qspi_fifo_controller.sv -----
// Every request (bus write, bus read, shift tick) runs the same way: busy rises
// for one cycle after start while the queue heads are read from memory, and
// the result strobe follows on the cycle after that. A new request is not
// accepted while busy is high.
// Synchronous reset empties both queues, clears control, mask and enable, and
// sets both thresholds to one. The receiver cannot stall the result strobe.
// ---------------------------------------------------------------------------
// Quad-SPI queue controller, manual mode
// Register view of an SPI master with transmit and receive word queues.
// ---------------------------------------------------------------------------
`default_nettype none
module qspi_fifo_controller #(
  parameter int FIFO_DEPTH = qspi_pkg::FifoDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [5:0]  reg_offset,
  input  wire logic [31:0] write_data,
  input  wire logic [7:0]  serial_in_byte,
  output logic             strobe,
  output logic [31:0]      read_data,
  output logic             tx_full,
  output logic             tx_empty,
  output logic             rx_not_empty,
  output logic             irq_pending,
  output logic             serial_out_valid,
  output logic [7:0]       serial_out_byte,
  output logic             chip_select_active,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import qspi_pkg::*;
  `include "qspi_fifo_controller_macros.svh"

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

  // The request is latched at start; the queue heads appear in the next cycle,
  // when the request is executed and its result registered.
  logic          pend;
  logic [1:0]    p_func;
  logic [5:0]    p_off;
  logic [31:0]   p_wdata;
  logic [7:0]    p_sin;

  logic [AW-1:0] tx_head, rx_head;
  logic [CW-1:0] tx_count, rx_count;
  logic [1:0]    shift_idx;
  logic [31:0]   rx_asm;
  logic [31:0]   control_word;
  logic [6:0]    irq_mask;
  logic          enabled, running;
  logic [6:0]    tx_thr, rx_thr;

  logic [33:0]   tx_rd;
  logic [31:0]   rx_rd;
  logic          tx_we, rx_we;
  logic [AW-1:0] tx_waddr, rx_waddr;
  logic [33:0]   tx_wdata;
  logic [31:0]   rx_wdata;

  result_t       res;

  assign busy = pend;
  // Configuration is taken only while no request is in flight.
  assign cfg_ready = !pend;

  function automatic logic [6:0] clamp_thr(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if ({2'b0, v} > 9'(FIFO_DEPTH)) r = 7'(FIFO_DEPTH);
    else r = v;
    return r;
  endfunction

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a,
                                         input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, {1'b0, a} + b};
    if (s >= (CW+1)'(FIFO_DEPTH)) s = s - (CW+1)'(FIFO_DEPTH);
    return s[AW-1:0];
  endfunction

  // Reads always address the current heads; the heads only move in the
  // execute cycle, so the registered data matches the head in use.
  qspi_fifo_mem #(.Depth(FIFO_DEPTH), .Width(34)) u_tx_mem (
    .clk(clk), .wr_en(tx_we), .wr_addr(tx_waddr), .wr_data(tx_wdata),
    .rd_addr(tx_head), .rd_data(tx_rd)
  );
  qspi_fifo_mem #(.Depth(FIFO_DEPTH), .Width(32)) u_rx_mem (
    .clk(clk), .wr_en(rx_we), .wr_addr(rx_waddr), .wr_data(rx_wdata),
    .rd_addr(rx_head), .rd_data(rx_rd)
  );

  logic tick_go, tx_push, rx_pop, word_done, rx_push;
  logic [1:0] tx_len;
  logic [2:0] push_len;

  always_comb begin
    tick_go = pend && (p_func == FUNC_TICK) && enabled && running && (tx_count != '0);
    tx_len = tx_rd[33:32];
    // A stored length of zero stands for a four-byte word.
    word_done = tick_go && ({1'b0, shift_idx} + 3'd1 >=
                            ((tx_len == 2'd0) ? 3'd4 : {1'b0, tx_len}));
    rx_push = word_done && (rx_count < DEPTH_C);
    rx_pop = pend && (p_func == FUNC_READ) && (p_off == OFF_RXD) && (rx_count != '0);
    push_len = 3'd0;
    tx_wdata = {2'd0, p_wdata};
    if (pend && p_func == FUNC_WRITE) begin
      unique case (p_off)
        OFF_TXD4: begin push_len = 3'd4; tx_wdata = {2'd0, p_wdata}; end
        OFF_TXD1: begin push_len = 3'd1; tx_wdata = {2'd1, 24'd0, p_wdata[7:0]}; end
        OFF_TXD2: begin push_len = 3'd2; tx_wdata = {2'd2, 16'd0, p_wdata[15:0]}; end
        OFF_TXD3: begin push_len = 3'd3; tx_wdata = {2'd3, 8'd0, p_wdata[23:0]}; end
        default: push_len = 3'd0;
      endcase
    end
    tx_push = (push_len != 3'd0) && (tx_count < DEPTH_C);
    tx_we = tx_push;
    tx_waddr = wrap(tx_head, tx_count);
    rx_we = rx_push;
    rx_waddr = wrap(rx_head, rx_count);
    rx_wdata = {p_sin, rx_asm[31:8]};

    res = '0;
    if (tick_go) begin
      res.serial_out_valid = 1'b1;
      res.serial_out_byte = tx_rd[8*shift_idx +: 8];
    end
    if (pend && p_func == FUNC_READ) begin
      unique case (p_off)
        OFF_CTRL:     res.read_data = control_word;
        OFF_STATUS:   res.read_data = {26'd0, rx_count == DEPTH_C, rx_count >= CW'(rx_thr),
                                       tx_count == DEPTH_C, {1'b0, tx_count} < (CW+1)'(tx_thr),
                                       2'd0};
        OFF_IRQ_MASK: res.read_data = {25'd0, irq_mask};
        OFF_ENABLE:   res.read_data = {31'd0, enabled};
        OFF_RXD:      res.read_data = rx_pop ? rx_rd : 32'd0;
        OFF_TX_THR:   res.read_data = {25'd0, tx_thr};
        OFF_RX_THR:   res.read_data = {25'd0, rx_thr};
        default:      res.read_data = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      tx_head <= '0; tx_count <= '0; rx_head <= '0; rx_count <= '0;
      shift_idx <= '0; rx_asm <= '0; control_word <= '0; irq_mask <= '0;
      enabled <= 1'b0; running <= 1'b0; tx_thr <= 7'd1; rx_thr <= 7'd1;
      strobe <= 1'b0; serial_out_valid <= 1'b0;
    end else begin
      strobe <= pend;
      serial_out_valid <= res.serial_out_valid;
      pend <= start && !pend;
      if (start && !pend) begin
        p_func <= func; p_off <= reg_offset; p_wdata <= write_data; p_sin <= serial_in_byte;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TX_THR) tx_thr <= clamp_thr(cfg_data);
        else rx_thr <= clamp_thr(cfg_data);
      end
      if (pend && p_func == FUNC_WRITE) begin
        unique case (p_off)
          OFF_CTRL: begin
            if (p_wdata[CR_START_BIT]) running <= 1'b1;
            control_word <= p_wdata & ~(32'd1 << CR_START_BIT);
          end
          OFF_IRQ_EN:  irq_mask <= irq_mask | (p_wdata[6:0] & IRQ_BITS);
          OFF_IRQ_DIS: irq_mask <= irq_mask & ~(p_wdata[6:0] & IRQ_BITS);
          OFF_ENABLE:  enabled <= p_wdata[0];
          OFF_TX_THR:  tx_thr <= clamp_thr(p_wdata[6:0]);
          OFF_RX_THR:  rx_thr <= clamp_thr(p_wdata[6:0]);
          default: ;
        endcase
      end
      if (tx_push) tx_count <= tx_count + 1'b1;
      if (tick_go) begin
        if (word_done) begin
          rx_asm <= '0;
          shift_idx <= '0;
          tx_head <= wrap(tx_head, CW'(1));
          tx_count <= tx_count - 1'b1;
          if (tx_count == CW'(1)) running <= 1'b0;
        end else begin
          rx_asm <= rx_wdata;
          shift_idx <= shift_idx + 2'd1;
        end
      end
      if (rx_push) rx_count <= rx_count + 1'b1;
      if (rx_pop) begin
        rx_head <= wrap(rx_head, CW'(1));
        rx_count <= rx_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    read_data <= res.read_data;
    serial_out_byte <= res.serial_out_byte;
  end

  // Status outputs follow the state, so they are current during the strobe.
  always_comb begin
    tx_full = (tx_count == DEPTH_C);
    tx_empty = {1'b0, tx_count} < (CW+1)'(tx_thr);
    rx_not_empty = rx_count >= CW'(rx_thr);
    irq_pending = |({1'b0, rx_count == DEPTH_C, rx_not_empty, tx_full, tx_empty, 2'd0}
                    & irq_mask);
    chip_select_active = !control_word[CR_CS_OFF_BIT];
  end

  `QSPI_ASSERT_NEXT(a_strobe_follows, clk, rst, busy, strobe)
  `QSPI_ASSERT_IMP(a_no_double_busy, clk, rst, busy, !strobe)
  `QSPI_ASSERT_IMP(a_tx_bound, clk, rst, 1'b1, tx_count <= DEPTH_C && rx_count <= DEPTH_C)
  `QSPI_ASSERT_IMP(a_shift_only_strobe, clk, rst, serial_out_valid, strobe)
endmodule
`default_nettype wire

// ----- bench/qspi_fifo_controller_test.sv -----
// ---------------------------------------------------------------------------
// Quad-SPI queue controller testbench
// Drives bus writes, bus reads and shift ticks through the command port and
// checks every result strobe against an in-bench model of both queues.
// ---------------------------------------------------------------------------
module qspi_fifo_controller_test;
  import qspi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 4;

  // One expected result, packed in the order the fields are compared.
  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_full;
    logic        tx_empty;
    logic        rx_not_empty;
    logic        irq_pending;
    logic        serial_out_valid;
    logic [7:0]  serial_out_byte;
    logic        chip_select_active;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = FUNC_WRITE;
  logic [5:0]  reg_offset = '0;
  logic [31:0] write_data = '0;
  logic [7:0]  serial_in_byte = '0;
  logic        strobe;
  logic [31:0] read_data;
  logic        tx_full, tx_empty, rx_not_empty, irq_pending;
  logic        serial_out_valid, chip_select_active;
  logic [7:0]  serial_out_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_TX_THR;
  logic [6:0]  cfg_data = '0;

  qspi_fifo_controller uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Mirror of the block's state, kept in step with every accepted request.
  logic [31:0] tx_words [DEPTH];
  int          tx_bytes [DEPTH];
  int          tx_head, tx_level;
  logic [31:0] rx_words [DEPTH];
  int          rx_head, rx_level;
  int          byte_pos;
  logic [31:0] rx_packing;
  logic [31:0] control_reg;
  logic [6:0]  irq_enables;
  bit          enabled, running;
  int          tx_thr, rx_thr;

  outcome_t    pending_results[$];
  int          requests_sent, results_seen, mismatches, cycles;
  int          bytes_shifted, config_writes;
  bit          unpaced;
  bit          stray_result;

  function automatic int clamp_level(logic [6:0] v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  function automatic logic [31:0] status_bits();
    logic [31:0] s;
    s = '0;
    s[2] = tx_level < tx_thr;
    s[3] = tx_level >= DEPTH;
    s[4] = rx_level >= rx_thr;
    s[5] = rx_level >= DEPTH;
    return s;
  endfunction

  function automatic void queue_tx(logic [31:0] w, int n);
    int slot;
    if (tx_level >= DEPTH) return;
    slot = (tx_head + tx_level) % DEPTH;
    tx_words[slot] = w;
    tx_bytes[slot] = n;
    tx_level++;
  endfunction

  // Applies one request to the mirror and returns the result it should give.
  function automatic outcome_t apply_request(logic [1:0] f, logic [5:0] off,
                                             logic [31:0] wd, logic [7:0] sin);
    outcome_t r;
    logic [31:0] st;
    r = '0;
    case (f)
      FUNC_WRITE: begin
        case (off)
          OFF_CTRL: begin
            if (wd[CR_START_BIT]) running = 1'b1;
            control_reg = wd;
            control_reg[CR_START_BIT] = 1'b0;
          end
          OFF_IRQ_EN:  irq_enables = irq_enables | (wd[6:0] & IRQ_BITS);
          OFF_IRQ_DIS: irq_enables = irq_enables & ~(wd[6:0] & IRQ_BITS);
          OFF_ENABLE:  enabled = wd[0];
          OFF_TXD4:    queue_tx(wd, 4);
          OFF_TX_THR:  tx_thr = clamp_level(wd[6:0]);
          OFF_RX_THR:  rx_thr = clamp_level(wd[6:0]);
          OFF_TXD1:    queue_tx({24'd0, wd[7:0]}, 1);
          OFF_TXD2:    queue_tx({16'd0, wd[15:0]}, 2);
          OFF_TXD3:    queue_tx({8'd0, wd[23:0]}, 3);
          default: ;
        endcase
      end
      FUNC_READ: begin
        case (off)
          OFF_CTRL:     r.read_data = control_reg;
          OFF_STATUS:   r.read_data = status_bits();
          OFF_IRQ_MASK: r.read_data = {25'd0, irq_enables};
          OFF_ENABLE:   r.read_data = {31'd0, enabled};
          OFF_RXD: begin
            if (rx_level > 0) begin
              r.read_data = rx_words[rx_head];
              rx_head = (rx_head + 1) % DEPTH;
              rx_level--;
            end
          end
          OFF_TX_THR:   r.read_data = 32'(tx_thr);
          OFF_RX_THR:   r.read_data = 32'(rx_thr);
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (enabled && running && tx_level > 0) begin
          r.serial_out_valid = 1'b1;
          r.serial_out_byte = 8'(tx_words[tx_head] >> (8 * byte_pos));
          rx_packing = {sin, rx_packing[31:8]};
          byte_pos++;
          if (byte_pos >= tx_bytes[tx_head]) begin
            // A finished word lands in the receive queue unless it is full.
            if (rx_level < DEPTH) begin
              rx_words[(rx_head + rx_level) % DEPTH] = rx_packing;
              rx_level++;
            end
            rx_packing = '0;
            byte_pos = 0;
            tx_head = (tx_head + 1) % DEPTH;
            tx_level--;
            if (tx_level == 0) running = 1'b0;
          end
        end
      end
      default: ;
    endcase
    st = status_bits();
    r.tx_full = st[3];
    r.tx_empty = st[2];
    r.rx_not_empty = st[4];
    r.irq_pending = (st[6:0] & irq_enables) != 0;
    r.chip_select_active = !control_reg[CR_CS_OFF_BIT];
    return r;
  endfunction

  // Sends one request. Start is left high on return, so the next request
  // either follows at once or lowers it when its own gap begins.
  task automatic issue(logic [1:0] f, logic [5:0] off, logic [31:0] wd,
                       logic [7:0] sin);
    int gap;
    gap = unpaced ? 0 : $urandom_range(13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= f;
    reg_offset <= off;
    write_data <= wd;
    serial_in_byte <= sin;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(f, off, wd, sin));
    requests_sent++;
    if (f == FUNC_TICK && pending_results[$].serial_out_valid) bytes_shifted++;
  endtask

  // Lets every outstanding result arrive, then waits out SETTLE_CYCLES so that the
  // block is truly idle before a configuration write or the end of the run.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [0:0] idx, logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TX_THR) tx_thr = clamp_level(v);
    else rx_thr = clamp_level(v);
    config_writes++;
  endtask

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    outcome_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && strobe) begin
      got = '{read_data, tx_full, tx_empty, rx_not_empty, irq_pending,
              serial_out_valid, serial_out_byte, chip_select_active};
      results_seen++;
      if (pending_results.size() == 0) begin
        stray_result = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("Result strobe with nothing expected.");
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Result %0d differs: rd %h/%h full %b/%b empty %b/%b ",
                      "rxne %b/%b irq %b/%b sov %b/%b sob %h/%h cs %b/%b"},
                     results_seen, want.read_data, got.read_data,
                     want.tx_full, got.tx_full, want.tx_empty, got.tx_empty,
                     want.rx_not_empty, got.rx_not_empty,
                     want.irq_pending, got.irq_pending,
                     want.serial_out_valid, got.serial_out_valid,
                     want.serial_out_byte, got.serial_out_byte,
                     want.chip_select_active, got.chip_select_active);
        end
      end
    end
  end

  // Every register read straight after reset, a shift tick with nothing queued,
  // and the unused function code at an unlisted offset, which must leave everything as it was.
  task automatic test_reset_values();
    issue(FUNC_READ, OFF_CTRL, '0, '0);
    issue(FUNC_READ, OFF_STATUS, '0, '0);
    issue(FUNC_READ, OFF_IRQ_MASK, '0, '0);
    issue(FUNC_READ, OFF_ENABLE, '0, '0);
    issue(FUNC_READ, OFF_RXD, '0, '0);
    issue(FUNC_READ, OFF_TX_THR, '0, '0);
    issue(FUNC_READ, OFF_RX_THR, '0, '0);
    issue(FUNC_TICK, '0, '0, 8'hff);
    issue(FUNC_NOP, 6'h3f, 32'hffff_ffff, 8'hff);
  endtask

  // One transfer of each word width with extreme data, the mask corner
  // cases, threshold clamping over the bus and an empty receive read.
  task automatic test_directed_transfer();
    issue(FUNC_WRITE, OFF_IRQ_EN, 32'hffff_ffff, '0);
    issue(FUNC_WRITE, OFF_IRQ_DIS, 32'h0000_0004, '0);
    issue(FUNC_WRITE, OFF_ENABLE, 32'h0000_0001, '0);
    issue(FUNC_WRITE, OFF_TXD1, 32'hffff_ffff, '0);
    issue(FUNC_WRITE, OFF_TXD2, 32'h1234_5678, '0);
    issue(FUNC_WRITE, OFF_TXD3, 32'h89ab_cdef, '0);
    issue(FUNC_WRITE, OFF_TXD4, 32'h0000_0000, '0);
    issue(FUNC_WRITE, OFF_CTRL, 32'h0001_0400, '0);
    for (int i = 0; i < 10; i++) issue(FUNC_TICK, '0, '0, i[0] ? 8'hff : 8'h00);
    issue(FUNC_WRITE, OFF_RX_THR, 32'h0000_0000, '0);
    issue(FUNC_WRITE, OFF_TX_THR, 32'h0000_007f, '0);
    for (int i = 0; i < 5; i++) issue(FUNC_READ, OFF_RXD, '0, '0);
    issue(FUNC_WRITE, OFF_STATUS, 32'hffff_ffff, '0);
    issue(FUNC_READ, OFF_CTRL, '0, '0);
  endtask

  // A well-formed transfer with random content, sprinkled with random noise.
  task automatic random_transfer();
    int words, total, extra;
    logic [5:0] widths [4];
    logic [5:0] off;
    widths = '{OFF_TXD1, OFF_TXD2, OFF_TXD3, OFF_TXD4};
    words = $urandom_range(1, 6);
    total = 0;
    issue(FUNC_WRITE, OFF_ENABLE, {31'($urandom), ($urandom_range(9) != 0)}, '0);
    for (int i = 0; i < words; i++) begin
      off = widths[$urandom_range(3)];
      total += (off == OFF_TXD4) ? 4 : off - OFF_TXD1 + 1;
      issue(FUNC_WRITE, off, $urandom, '0);
    end
    issue(FUNC_WRITE, OFF_CTRL,
          ($urandom & ~32'h0001_0000) | (($urandom_range(7) != 0) << CR_START_BIT),
          '0);
    extra = $urandom_range(2);
    for (int i = 0; i < total + extra; i++) begin
      if ($urandom_range(9) == 0)
        issue(2'($urandom), 6'($urandom), $urandom, 8'($urandom));
      else if ($urandom_range(7) == 0) issue(FUNC_READ, OFF_STATUS, '0, '0);
      issue(FUNC_TICK, 6'($urandom), $urandom, 8'($urandom));
    end
    for (int i = 0; i <= words; i++) issue(FUNC_READ, OFF_RXD, $urandom, '0);
    if ($urandom_range(3) == 0)
      issue(FUNC_WRITE, $urandom_range(1) ? OFF_IRQ_EN : OFF_IRQ_DIS, $urandom, '0);
  endtask

  // Fills the transmit queue past its depth, then shifts enough to overrun
  // the receive queue, so both full flags and the dropped word are seen.
  task automatic fill_both_queues();
    issue(FUNC_WRITE, OFF_ENABLE, 32'h1, '0);
    for (int round = 0; round < 2; round++) begin
      for (int i = 0; i < DEPTH + 2; i++)
        issue(FUNC_WRITE, OFF_TXD1, $urandom, '0);
      issue(FUNC_READ, OFF_STATUS, '0, '0);
      issue(FUNC_WRITE, OFF_CTRL, 32'h0001_0000, '0);
      for (int i = 0; i < DEPTH + 1; i++) issue(FUNC_TICK, '0, '0, 8'($urandom));
    end
    issue(FUNC_READ, OFF_STATUS, '0, '0);
    for (int i = 0; i < DEPTH + 2; i++) issue(FUNC_READ, OFF_RXD, '0, '0);
  endtask

  task automatic test_random_traffic(int target);
    logic [6:0] corners [4];
    corners = '{7'd0, 7'd1, 7'd64, 7'd127};
    while (requests_sent < target) begin
      unpaced = ($urandom_range(4) == 0);
      if ($urandom_range(11) == 0) begin
        write_threshold(CFG_TX_THR,
                        $urandom_range(1) ? corners[$urandom_range(3)] : 7'($urandom));
        write_threshold(CFG_RX_THR,
                        $urandom_range(1) ? corners[$urandom_range(3)] : 7'($urandom));
      end
      if ($urandom_range(60) == 0) fill_both_queues();
      else random_transfer();
    end
    unpaced = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tx_words[i] = '0;
      tx_bytes[i] = 0;
      rx_words[i] = '0;
    end
    tx_head = 0; tx_level = 0; rx_head = 0; rx_level = 0;
    byte_pos = 0; rx_packing = '0; control_reg = '0; irq_enables = '0;
    enabled = 1'b0; running = 1'b0; tx_thr = 1; rx_thr = 1;
    unpaced = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    write_threshold(CFG_TX_THR, 7'd64);
    write_threshold(CFG_RX_THR, 7'd0);
    test_directed_transfer();
    write_threshold(CFG_TX_THR, 7'd127);
    write_threshold(CFG_RX_THR, 7'd1);
    fill_both_queues();
    test_random_traffic(1500);
    drain();

    $display("Sent %0d requests, checked %0d results, shifted %0d bytes,",
             requests_sent, results_seen, bytes_shifted);
    $display("with %0d threshold writes on the configuration channel.",
             config_writes);
    if (mismatches == 0 && !stray_result) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
